// ===== hw/rtl/csvfs_pkg.sv =====
package csvfs_pkg;

    // Default sizes
    localparam int FIELD_BYTES_DEF = 64;
    localparam int MAX_COLUMNS_DEF = 256;

    // Results one input transfer may produce at most
    localparam int RESULT_LIMIT = 64;
    localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

    // Character codes
    localparam logic [7:0] LF_BYTE    = 8'd10;
    localparam logic [7:0] CR_BYTE    = 8'd13;
    localparam logic [7:0] TAB_BYTE   = 8'd9;
    localparam logic [7:0] SPACE_BYTE = 8'd32;
    localparam logic [7:0] QUOTE_BYTE = 8'd34;
    localparam logic [7:0] COMMA_BYTE = 8'd44;

    // Register file
    localparam int         ADDR_W          = 3;
    localparam logic       REG_IDX_HDR_SEP = 1'b0;
    localparam logic [7:0] HDR_SEP_RESET   = COMMA_BYTE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAIN,
        ST_EMIT,
        ST_POST,
        ST_TAIL,
        ST_OPENQ,
        ST_FLUSH
    } csvfs_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic emit_setup;
        logic emit_hdr;
        logic emit_row_end;
        logic emit_cap;
        logic emit_run;
        logic openq_push;
        logic clear_field;
        logic store_byte;
        logic store_lf;
        logic set_hf;
        logic sol_set;
        logic sol_clr;
        logic ls_set;
        logic ls_clr;
        logic quote_toggle;
        logic hc_inc;
        logic fir_inc;
        logic fir_clr;
        logic reset_all;
    } csvfs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_lf;
        logic is_last;
        logic is_sep;
        logic is_quote;
        logic is_comma;
        logic hf;
        logic ls;
        logic iq;
        logic sol;
        logic out_free;
        logic emit_last;
    } csvfs_sts_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == SPACE_BYTE) || (b == TAB_BYTE) || (b == CR_BYTE) || (b == LF_BYTE);
    endfunction

endpackage

// ===== hw/rtl/csvfs_ctrl.sv =====
module csvfs_ctrl
    import csvfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  csvfs_sts_t sts,
    output csvfs_cmd_t cmd
);

    csvfs_state_t state_reg, state_next;
    logic         emitted_reg, emitted_next;  // main phase of this byte sent a field
    logic         tail_reg, tail_next;        // field burst belongs to end of data

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            emitted_reg <= 1'b0;
            tail_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
            tail_reg    <= tail_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        emitted_next = emitted_reg;
        tail_next    = tail_reg;
        cmd          = '0;
        s_tready     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                emitted_next = 1'b0;
                tail_next    = 1'b0;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MAIN;
                end
            end

            // field finished by this byte, if any
            ST_MAIN: begin
                if ((sts.is_lf && sts.ls && (!sts.hf || !sts.iq)) ||
                    (!sts.is_lf && !sts.hf && sts.sol) ||
                    (!sts.is_lf && sts.hf && sts.is_comma && !sts.iq)) begin
                    cmd.emit_setup   = 1'b1;
                    cmd.emit_hdr     = !sts.hf;
                    cmd.emit_row_end = sts.is_lf;
                    cmd.emit_cap     = sts.is_last && !sts.is_lf;
                    cmd.hc_inc       = !sts.hf;
                    cmd.fir_inc      = sts.hf && !sts.is_lf;
                    emitted_next     = 1'b1;
                    state_next       = ST_EMIT;
                end else begin
                    emitted_next = 1'b0;
                    state_next   = ST_POST;
                end
            end

            ST_EMIT: begin
                cmd.emit_run = 1'b1;
                if (sts.out_free && sts.emit_last) begin
                    state_next = tail_reg ? ST_FLUSH : ST_POST;
                end
            end

            // store the byte and update line state
            ST_POST: begin
                cmd.clear_field = emitted_reg;
                if (sts.is_lf) begin
                    cmd.ls_clr = 1'b1;
                    if (!sts.hf) begin
                        cmd.set_hf  = sts.ls;
                        cmd.sol_clr = 1'b1;
                    end else if (sts.iq) begin
                        cmd.store_lf = sts.ls;
                    end else begin
                        cmd.fir_clr = emitted_reg;
                    end
                end else if (!sts.hf) begin
                    cmd.ls_set  = 1'b1;
                    cmd.sol_clr = emitted_reg;
                    if (sts.is_sep) begin
                        cmd.sol_set = 1'b1;
                    end else begin
                        cmd.store_byte = 1'b1;
                    end
                end else begin
                    cmd.ls_set = 1'b1;
                    if (sts.is_quote) begin
                        cmd.quote_toggle = 1'b1;
                        cmd.store_byte   = 1'b1;
                    end else if (!(sts.is_comma && !sts.iq)) begin
                        cmd.store_byte = 1'b1;
                    end
                end
                state_next = sts.is_last ? ST_TAIL : ST_IDLE;
            end

            // end of data acts as a line end
            ST_TAIL: begin
                if (sts.hf && sts.iq) begin
                    state_next = ST_OPENQ;
                end else if (sts.ls) begin
                    cmd.emit_setup   = 1'b1;
                    cmd.emit_hdr     = !sts.hf;
                    cmd.emit_row_end = 1'b1;
                    cmd.hc_inc       = !sts.hf;
                    tail_next        = 1'b1;
                    state_next       = ST_EMIT;
                end else begin
                    state_next = ST_FLUSH;
                end
            end

            ST_OPENQ: begin
                cmd.openq_push = 1'b1;
                if (sts.out_free) begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                cmd.reset_all = 1'b1;
                tail_next     = 1'b0;
                state_next    = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/csvfs_datapath.sv =====
module csvfs_datapath
    import csvfs_pkg::*;
#(
    parameter int FIELD_BYTES = FIELD_BYTES_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic [7:0] hdr_sep,
    input  csvfs_cmd_t cmd,
    output csvfs_sts_t sts,
    input  logic       m_tready,
    output logic       m_valid,
    output logic [7:0] m_byte,
    output logic       m_present,
    output logic       m_field_done,
    output logic       m_row_done,
    output logic       m_hdr,
    output logic       m_trunc,
    output logic       m_mism,
    output logic       m_openq
);

    localparam int LEN_W = $clog2(FIELD_BYTES + 1);
    localparam int IDX_W = $clog2(FIELD_BYTES);
    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    // Held input transfer
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Line and quote state
    logic iq_reg, iq_next;
    logic strip_reg, strip_next;
    logic ls_reg, ls_next;
    logic hf_reg, hf_next;
    logic sol_reg, sol_next;
    logic ovf_reg, ovf_next;

    // Field store and trim trackers
    logic [7:0]       store_mem [FIELD_BYTES];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             lo0f_reg, lo0f_next;   // first non-space found
    logic [IDX_W-1:0] lo0_reg, lo0_next;
    logic             lo1f_reg, lo1f_next;   // first non-space past index 0 found
    logic [IDX_W-1:0] lo1_reg, lo1_next;
    logic [LEN_W-1:0] hi_all_reg, hi_all_next;   // trim end over all bytes
    logic [LEN_W-1:0] hi_prev_reg, hi_prev_next; // trim end without last byte

    // Column counters
    logic [CNT_W-1:0] hc_reg, hc_next;
    logic [CNT_W-1:0] fir_reg, fir_next;

    // Burst descriptor and read pointer
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             d_empty_reg, d_hdr_reg, d_row_reg, d_trunc_reg, d_mism_reg;
    logic [7:0]       rd_data_reg;

    // Output register
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_present_reg, m_done_reg, m_row_reg, m_hdr_reg;
    logic       m_trunc_reg, m_mism_reg, m_openq_reg;

    // Combinational helpers
    logic             out_free;
    logic             push_field, push_openq, push_byte;
    logic [LEN_W-1:0] len_b, hi_all_b, hi_prev_b;
    logic             lo0f_b, lo1f_b;
    logic             do_store, mem_we, wr_ns;
    logic [7:0]       wr_data;
    logic [IDX_W-1:0] wr_idx;
    logic             strip_sel, span_ok, cap_hit;
    logic [IDX_W-1:0] lo_sel;
    logic [LEN_W-1:0] cnt_raw, cnt_sel;
    logic [CNT_W-1:0] fir_sat;

    assign out_free   = !m_valid_reg || m_tready;
    assign push_field = cmd.emit_run && out_free;
    assign push_openq = cmd.openq_push && out_free;
    assign push_byte  = push_field && !d_empty_reg;
    assign fir_sat    = (fir_reg < CNT_W'(MAX_COLUMNS)) ? CNT_W'(fir_reg + 1'b1) : fir_reg;

    // Status
    always_comb begin
        sts.is_lf     = (in_byte_reg == LF_BYTE);
        sts.is_last   = in_last_reg;
        sts.is_sep    = (in_byte_reg == hdr_sep);
        sts.is_quote  = (in_byte_reg == QUOTE_BYTE);
        sts.is_comma  = (in_byte_reg == COMMA_BYTE);
        sts.hf        = hf_reg;
        sts.ls        = ls_reg;
        sts.iq        = iq_reg;
        sts.sol       = sol_reg;
        sts.out_free  = out_free;
        sts.emit_last = d_empty_reg || (rem_reg == LEN_W'(1));
    end

    // Trimmed span of the stored field
    always_comb begin
        strip_sel = !cmd.emit_hdr && strip_reg;
        if (strip_sel) begin
            span_ok = (len_reg >= LEN_W'(2)) && lo1f_reg && (LEN_W'(lo1_reg) < hi_prev_reg);
            lo_sel  = lo1_reg;
            cnt_raw = LEN_W'(hi_prev_reg - LEN_W'(lo1_reg));
        end else begin
            span_ok = lo0f_reg;
            lo_sel  = lo0_reg;
            cnt_raw = LEN_W'(hi_all_reg - LEN_W'(lo0_reg));
        end
        if (!span_ok) begin
            cnt_raw = '0;
        end
        cap_hit = cmd.emit_cap && (RES_W'(cnt_raw) > RES_W'(RESULT_LIMIT - 1));
        cnt_sel = cap_hit ? LEN_W'(RESULT_LIMIT - 1) : cnt_raw;
    end

    // Field and line state update
    always_comb begin
        len_b     = cmd.clear_field ? '0   : len_reg;
        lo0f_b    = cmd.clear_field ? 1'b0 : lo0f_reg;
        lo1f_b    = cmd.clear_field ? 1'b0 : lo1f_reg;
        hi_all_b  = cmd.clear_field ? '0   : hi_all_reg;
        hi_prev_b = cmd.clear_field ? '0   : hi_prev_reg;

        len_next     = len_b;
        lo0f_next    = lo0f_b;
        lo0_next     = lo0_reg;
        lo1f_next    = lo1f_b;
        lo1_next     = lo1_reg;
        hi_all_next  = hi_all_b;
        hi_prev_next = hi_prev_b;
        ovf_next     = cmd.clear_field ? 1'b0 : ovf_reg;
        strip_next   = cmd.clear_field ? 1'b0 : strip_reg;
        iq_next      = iq_reg;
        ls_next      = ls_reg;
        hf_next      = hf_reg;
        sol_next     = sol_reg;
        hc_next      = hc_reg;
        fir_next     = fir_reg;

        do_store = cmd.store_byte || cmd.store_lf;
        wr_data  = cmd.store_lf ? LF_BYTE : in_byte_reg;
        wr_ns    = !is_space(wr_data);
        wr_idx   = len_b[IDX_W-1:0];
        mem_we   = 1'b0;

        // append one byte, or mark the overflow
        if (do_store) begin
            if (len_b < LEN_W'(FIELD_BYTES)) begin
                mem_we       = 1'b1;
                len_next     = LEN_W'(len_b + 1'b1);
                hi_prev_next = hi_all_b;
                if (wr_ns) begin
                    hi_all_next = LEN_W'(len_b + 1'b1);
                    if (!lo0f_b) begin
                        lo0f_next = 1'b1;
                        lo0_next  = wr_idx;
                    end
                    if (!lo1f_b && (len_b != '0)) begin
                        lo1f_next = 1'b1;
                        lo1_next  = wr_idx;
                    end
                end
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.quote_toggle) begin
            if (iq_reg) begin
                iq_next    = 1'b0;
                strip_next = 1'b1;
            end else begin
                iq_next = 1'b1;
            end
        end

        if (cmd.ls_set) ls_next = 1'b1;
        if (cmd.ls_clr) ls_next = 1'b0;
        if (cmd.set_hf) hf_next = 1'b1;
        if (cmd.sol_clr) sol_next = 1'b0;
        if (cmd.sol_set) sol_next = 1'b1;

        if (cmd.hc_inc && (hc_reg < CNT_W'(MAX_COLUMNS))) hc_next = CNT_W'(hc_reg + 1'b1);
        if (cmd.fir_inc) fir_next = fir_sat;
        if (cmd.fir_clr) fir_next = '0;

        // end of data: back to the start of a new text
        if (cmd.reset_all) begin
            len_next     = '0;
            lo0f_next    = 1'b0;
            lo1f_next    = 1'b0;
            hi_all_next  = '0;
            hi_prev_next = '0;
            ovf_next     = 1'b0;
            strip_next   = 1'b0;
            iq_next      = 1'b0;
            ls_next      = 1'b0;
            hf_next      = 1'b0;
            sol_next     = 1'b0;
            hc_next      = '0;
            fir_next     = '0;
        end
    end

    // Read pointer walks the burst; the read data register follows it
    always_comb begin
        if (cmd.emit_setup) begin
            ptr_next = lo_sel;
            rem_next = cnt_sel;
        end else if (push_byte) begin
            ptr_next = IDX_W'(ptr_reg + 1'b1);
            rem_next = LEN_W'(rem_reg - 1'b1);
        end else begin
            ptr_next = ptr_reg;
            rem_next = rem_reg;
        end
    end

    // Field store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= store_mem[ptr_next];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iq_reg      <= 1'b0;
            strip_reg   <= 1'b0;
            ls_reg      <= 1'b0;
            hf_reg      <= 1'b0;
            sol_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            len_reg     <= '0;
            lo0f_reg    <= 1'b0;
            lo1f_reg    <= 1'b0;
            hi_all_reg  <= '0;
            hi_prev_reg <= '0;
            hc_reg      <= '0;
            fir_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            iq_reg      <= iq_next;
            strip_reg   <= strip_next;
            ls_reg      <= ls_next;
            hf_reg      <= hf_next;
            sol_reg     <= sol_next;
            ovf_reg     <= ovf_next;
            len_reg     <= len_next;
            lo0f_reg    <= lo0f_next;
            lo1f_reg    <= lo1f_next;
            hi_all_reg  <= hi_all_next;
            hi_prev_reg <= hi_prev_next;
            hc_reg      <= hc_next;
            fir_reg     <= fir_next;
            if (push_field || push_openq) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        lo0_reg <= lo0_next;
        lo1_reg <= lo1_next;
        ptr_reg <= ptr_next;
        rem_reg <= rem_next;
        if (cmd.load_in) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (cmd.emit_setup) begin
            d_empty_reg <= (cnt_sel == '0);
            d_hdr_reg   <= cmd.emit_hdr;
            d_row_reg   <= cmd.emit_row_end;
            d_trunc_reg <= ovf_reg || cap_hit;
            d_mism_reg  <= !cmd.emit_hdr && cmd.emit_row_end && (fir_sat != hc_reg);
        end
        if (push_field) begin
            m_byte_reg    <= d_empty_reg ? 8'd0 : rd_data_reg;
            m_present_reg <= !d_empty_reg;
            m_done_reg    <= sts.emit_last;
            m_row_reg     <= sts.emit_last && d_row_reg;
            m_hdr_reg     <= d_hdr_reg;
            m_trunc_reg   <= d_trunc_reg;
            m_mism_reg    <= sts.emit_last && d_mism_reg;
            m_openq_reg   <= 1'b0;
        end else if (push_openq) begin
            m_byte_reg    <= 8'd0;
            m_present_reg <= 1'b0;
            m_done_reg    <= 1'b0;
            m_row_reg     <= 1'b0;
            m_hdr_reg     <= 1'b0;
            m_trunc_reg   <= 1'b0;
            m_mism_reg    <= 1'b0;
            m_openq_reg   <= 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_byte       = m_byte_reg;
    assign m_present    = m_present_reg;
    assign m_field_done = m_done_reg;
    assign m_row_done   = m_row_reg;
    assign m_hdr        = m_hdr_reg;
    assign m_trunc      = m_trunc_reg;
    assign m_mism       = m_mism_reg;
    assign m_openq      = m_openq_reg;

    // Store fill never passes its size
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(FIELD_BYTES))
        else $error("field length beyond store size");

    // Leading trim index lies inside the stored bytes
    a_lo0_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        lo0f_reg |-> (LEN_W'(lo0_reg) < len_reg))
        else $error("trim start outside stored field");

    // Trim end without the last byte never passes the full trim end
    a_hi_order: assert property (@(posedge aclk) disable iff (!aresetn)
        hi_prev_reg <= hi_all_reg)
        else $error("trim end trackers out of order");

    // Quote stripping only arises on data lines
    a_strip_data: assert property (@(posedge aclk) disable iff (!aresetn)
        strip_reg |-> hf_reg)
        else $error("quote strip pending on header line");

endmodule

// ===== hw/rtl/csv_field_splitter.sv =====
// CSV field splitter.
// Input: s_tdata carries one text byte per transfer, s_tlast marks the final
// byte of a text (a line end is implied after it). Output: one transfer per
// byte of each finished, trimmed field; an empty field gives one transfer with
// byte_present low. m_tlast marks the last transfer of a field.
// The first non-empty line is the header, split on the separator in the APB
// register at address 0 (reset value comma); data lines split on commas
// outside double quotes.
// A byte that only gets stored passes accept, decode and store; one that
// ends a field also sends one result per cycle while the receiver is ready
// (burst set up in decode), bounded by the single read port of the field
// store. The final byte then adds tail and flush steps around the closing
// burst. Reset clears all parse state and the output register; the separator
// returns to comma. The end of a text also clears parse state, keeping the
// separator. A stalled receiver holds the output register and the burst
// pauses; s_tready stays low until the current byte is fully handled.
module csv_field_splitter
    import csvfs_pkg::*;
#(
    parameter int FIELD_BYTES = FIELD_BYTES_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // end_of_data
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] field_byte, [8] row_done,
                                         // [9] field_truncated,
                                         // [10] column_mismatch,
                                         // [11] open_quote_at_end, [15:12] zero
    output logic [1:0]        m_tuser,   // [0] byte_present, [1] from_header
    output logic              m_tlast,   // field_done
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] hdr_sep_reg;
    csvfs_cmd_t cmd;
    csvfs_sts_t sts;
    logic [7:0] out_byte;
    logic       out_present, out_done, out_row, out_hdr;
    logic       out_trunc, out_mism, out_openq;

    // Register file
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_sep_reg <= HDR_SEP_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1] == REG_IDX_HDR_SEP)) begin
            hdr_sep_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_IDX_HDR_SEP) ? {24'd0, hdr_sep_reg} : 32'd0;

    csvfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csvfs_datapath #(
        .FIELD_BYTES (FIELD_BYTES),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .hdr_sep      (hdr_sep_reg),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .m_valid      (m_tvalid),
        .m_byte       (out_byte),
        .m_present    (out_present),
        .m_field_done (out_done),
        .m_row_done   (out_row),
        .m_hdr        (out_hdr),
        .m_trunc      (out_trunc),
        .m_mism       (out_mism),
        .m_openq      (out_openq)
    );

    // Result packing
    assign m_tdata = {4'd0, out_openq, out_mism, out_trunc, out_row, out_byte};
    assign m_tuser = {out_hdr, out_present};
    assign m_tlast = out_done;

endmodule
